FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on a clock with a synchronous active-high reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ulbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulbp_pkg
// shared widths, bin lookup table and phase type of the uniform lbp histogram
// ----------------------------------------------------------------------------
package ulbp_pkg;

   localparam int unsigned PIX_W    = 8;
   localparam int unsigned CODE_W   = 8;
   localparam int unsigned BIN_W    = 6;
   localparam int unsigned NUM_BINS = 59;
   localparam int unsigned CNT_W    = 11;
   localparam int unsigned FRAC_W   = 17;

   localparam logic [BIN_W-1:0]  LAST_BIN = BIN_W'(NUM_BINS - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   typedef logic [BIN_W-1:0] bin_lut_type [256];

   typedef enum logic {
      PH_COUNT,
      PH_DRAIN
   } phase_type;

   // at most two circular 0/1 transitions
   function automatic logic is_uniform(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] diff;
      diff = code ^ {code[0], code[CODE_W-1:1]};
      return ($countones(diff) <= 2);
   endfunction

   // uniform codes take bins 1.. in ascending order, the rest bin 0
   function automatic bin_lut_type build_bin_lut();
      bin_lut_type lut;
      int unsigned next_bin;
      next_bin = 1;
      for (int c = 0; c < 256; c++) begin
         if (is_uniform(CODE_W'(c))) begin
            lut[c]   = BIN_W'(next_bin);
            next_bin = next_bin + 1;
         end else begin
            lut[c] = '0;
         end
      end
      return lut;
   endfunction

   localparam bin_lut_type BIN_LUT = build_bin_lut();

endpackage

FILE: hw/rtl/ulbp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulbp_req_if
// pixel neighborhood channel: valid/ready with one 3x3 window per transaction
// ----------------------------------------------------------------------------
interface ulbp_req_if import ulbp_pkg::*; ;

   logic              valid;
   logic              ready;
   logic [PIX_W-1:0]  center_pixel;
   logic [PIX_W-1:0]  up_left;
   logic [PIX_W-1:0]  left;
   logic [PIX_W-1:0]  down_left;
   logic [PIX_W-1:0]  down;
   logic [PIX_W-1:0]  down_right;
   logic [PIX_W-1:0]  right;
   logic [PIX_W-1:0]  up_right;
   logic [PIX_W-1:0]  up;
   logic              inside_image;
   logic              cell_end;

   modport source (
      output valid, center_pixel, up_left, left, down_left, down,
             down_right, right, up_right, up, inside_image, cell_end,
      input  ready
   );

   modport sink (
      input  valid, center_pixel, up_left, left, down_left, down,
             down_right, right, up_right, up, inside_image, cell_end,
      output ready
   );

endinterface

FILE: hw/rtl/ulbp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulbp_rsp_if
// histogram bin channel: valid/ready with one normalized bin per transaction
// ----------------------------------------------------------------------------
interface ulbp_rsp_if import ulbp_pkg::*; ;

   logic              valid;
   logic              ready;
   logic [BIN_W-1:0]  bin_index;
   logic [FRAC_W-1:0] bin_fraction;
   logic              last_bin;

   modport source (
      output valid, bin_index, bin_fraction, last_bin,
      input  ready
   );

   modport sink (
      input  valid, bin_index, bin_fraction, last_bin,
      output ready
   );

endinterface

FILE: hw/rtl/uniform_lbp_cell_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_lbp_cell_histogram
// 59-bin uniform lbp histogram of one cell, emitted as Q1.16 fractions
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+------------------------------------------
//  req_ch   | in  | valid/ready | center, 8 neighbors, inside_image, cell_end
//  rsp_ch   | out | valid/ready | bin_index, bin_fraction, last_bin
//
//  one pixel per cycle: input register, code and bin lookup with counter
//  read, then increment and write back (one forward path covers a repeat bin)
//  on cell_end, input stalls while 59 bins are read one per cycle through a
//  3-stage divide-by-constant pipe; the burst rate follows rsp_ch.ready
//  reset clears the counter valid bits at once, so no clearing pass is needed
//  the last burst read clears the valid bits again for the next cell
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uniform_lbp_cell_histogram import ulbp_pkg::*; #(
   parameter int unsigned CELL_SIZE = 40
) (
   input  logic      clock,
   input  logic      reset,
   ulbp_req_if.sink  req_ch,
   ulbp_rsp_if.source rsp_ch
);

   localparam int unsigned PIXELS  = (CELL_SIZE == 0) ? 1 : CELL_SIZE * CELL_SIZE;
   localparam int unsigned PXL_W   = $clog2(PIXELS + 1);
   localparam int unsigned RCP_W   = 29;
   localparam int unsigned RCP_SH  = 12;
   localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << 28) / PIXELS);
   localparam int unsigned PROD1_W = CNT_W + RCP_W;
   localparam int unsigned PROD2_W = FRAC_W + PXL_W;
   localparam int unsigned DIFF_W  = CNT_W + 16;

   // ---------------------------------------------------------------- stage 1
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_go;
   logic [PIX_W-1:0]  s1_center_ff;
   logic [PIX_W-1:0]  s1_nb_ff [CODE_W];
   logic              s1_inside_ff;
   logic              s1_end_ff;
   logic [CODE_W-1:0] s1_code;
   logic [BIN_W-1:0]  s1_bin;
   logic              req_take;

   // ---------------------------------------------------------------- stage 2
   logic              s2_valid_ff;
   logic              s2_end_ff;
   logic [BIN_W-1:0]  s2_bin_ff;
   logic [CNT_W-1:0]  rd_cnt_ff;
   logic              rd_ok_ff;
   logic              fwd_ff;
   logic [CNT_W-1:0]  fwd_cnt_ff;
   logic [CNT_W-1:0]  s2_old;
   logic [CNT_W-1:0]  s2_new;

   // ---------------------------------------------------------------- storage
   logic [CNT_W-1:0]  cnt_mem [NUM_BINS];
   logic              cnt_valid_ff [NUM_BINS];
   logic              cnt_valid_in [NUM_BINS];

   // ---------------------------------------------------------------- burst
   phase_type         phase_ff, phase_in;
   logic [BIN_W-1:0]  idx_ff, idx_in;
   logic              adv;
   logic              issue;
   logic              clear_all;

   logic              d1_valid_ff;
   logic [BIN_W-1:0]  d1_idx_ff;
   logic [CNT_W-1:0]  d1_rd_ff;
   logic              d1_ok_ff;
   logic [CNT_W-1:0]  d1_cnt;
   logic              d1_sat;
   logic [PROD1_W-1:0] d1_prod;

   logic              d2_valid_ff;
   logic [BIN_W-1:0]  d2_idx_ff;
   logic [CNT_W-1:0]  d2_cnt_ff;
   logic              d2_sat_ff;
   logic [FRAC_W-1:0] d2_q_ff;

   logic              d3_valid_ff;
   logic [BIN_W-1:0]  d3_idx_ff;
   logic [CNT_W-1:0]  d3_cnt_ff;
   logic              d3_sat_ff;
   logic [FRAC_W-1:0] d3_q_ff;
   logic [PROD2_W-1:0] d3_prod_ff;
   logic [DIFF_W-1:0] d3_diff;
   logic [FRAC_W-1:0] d3_frac;

   logic              rsp_valid_ff;
   logic [BIN_W-1:0]  rsp_idx_ff;
   logic [FRAC_W-1:0] rsp_frac_ff;
   logic              rsp_last_ff;

   // ------------------------------------------------------------ pixel path
   always_comb begin
      for (int i = 0; i < CODE_W; i++) begin
         s1_code[i] = s1_inside_ff && (s1_nb_ff[i] > s1_center_ff);
      end
   end

   assign s1_bin   = BIN_LUT[s1_code];
   // hold the pixel while its predecessor opens a burst or the burst runs
   assign s1_go    = s1_valid_ff && (phase_ff == PH_COUNT) && !(s2_valid_ff && s2_end_ff);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_take = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_center_ff <= req_ch.center_pixel;
         s1_nb_ff[0]  <= req_ch.up_left;
         s1_nb_ff[1]  <= req_ch.left;
         s1_nb_ff[2]  <= req_ch.down_left;
         s1_nb_ff[3]  <= req_ch.down;
         s1_nb_ff[4]  <= req_ch.down_right;
         s1_nb_ff[5]  <= req_ch.right;
         s1_nb_ff[6]  <= req_ch.up_right;
         s1_nb_ff[7]  <= req_ch.up;
         s1_inside_ff <= req_ch.inside_image;
         s1_end_ff    <= req_ch.cell_end;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_bin_ff  <= s1_bin;
         s2_end_ff  <= s1_end_ff;
         rd_cnt_ff  <= cnt_mem[s1_bin];
         rd_ok_ff   <= cnt_valid_ff[s1_bin];
         fwd_cnt_ff <= s2_new;
      end
   end

   // counter value being written this cycle bypasses the stale read
   assign s2_old = fwd_ff ? fwd_cnt_ff : (rd_ok_ff ? rd_cnt_ff : '0);
   assign s2_new = (s2_old == CNT_MAX) ? s2_old : s2_old + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         cnt_mem[s2_bin_ff] <= s2_new;
      end
   end

   assign clear_all = issue && (idx_ff == LAST_BIN);

   always_comb begin
      for (int b = 0; b < NUM_BINS; b++) begin
         cnt_valid_in[b] = clear_all ? 1'b0 : cnt_valid_ff[b];
      end
      if (s2_valid_ff) begin
         cnt_valid_in[s2_bin_ff] = 1'b1;
      end
   end

   // ------------------------------------------------------------ burst fsm
   assign adv   = !rsp_valid_ff || rsp_ch.ready;
   assign issue = (phase_ff == PH_DRAIN) && adv;

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      case (phase_ff)
         PH_COUNT: begin
            if (s2_valid_ff && s2_end_ff) begin
               phase_in = PH_DRAIN;
               idx_in   = '0;
            end
         end
         PH_DRAIN: begin
            if (adv) begin
               if (idx_ff == LAST_BIN) begin
                  phase_in = PH_COUNT;
               end
               idx_in = idx_ff + BIN_W'(1);
            end
         end
         default: begin
            phase_in = PH_COUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         phase_ff     <= PH_COUNT;
         idx_ff       <= '0;
         d1_valid_ff  <= 1'b0;
         d2_valid_ff  <= 1'b0;
         d3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BINS; b++) begin
            cnt_valid_ff[b] <= 1'b0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_go;
         fwd_ff       <= s1_go && s2_valid_ff && (s2_bin_ff == s1_bin);
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         cnt_valid_ff <= cnt_valid_in;
         if (adv) begin
            d1_valid_ff  <= issue;
            d2_valid_ff  <= d1_valid_ff;
            d3_valid_ff  <= d2_valid_ff;
            rsp_valid_ff <= d3_valid_ff;
         end
      end
   end

   // ------------------------------------------------------------ divide pipe
   // q ~ cnt * 2^16 / PIXELS via a 2^28 reciprocal, off by at most one
   always_ff @(posedge clock) begin
      if (issue) begin
         d1_rd_ff <= cnt_mem[idx_ff];
         d1_ok_ff <= cnt_valid_ff[idx_ff];
      end
      if (adv) begin
         d1_idx_ff <= idx_ff;
      end
   end

   assign d1_cnt  = d1_ok_ff ? d1_rd_ff : '0;
   assign d1_sat  = (32'(d1_cnt) >= PIXELS);
   assign d1_prod = PROD1_W'(d1_cnt) * PROD1_W'(RECIP);

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_idx_ff  <= d1_idx_ff;
         d2_cnt_ff  <= d1_cnt;
         d2_sat_ff  <= d1_sat;
         d2_q_ff    <= d1_prod[RCP_SH +: FRAC_W];
         d3_idx_ff  <= d2_idx_ff;
         d3_cnt_ff  <= d2_cnt_ff;
         d3_sat_ff  <= d2_sat_ff;
         d3_q_ff    <= d2_q_ff;
         d3_prod_ff <= PROD2_W'(d2_q_ff) * PROD2_W'(PIXELS);
         rsp_idx_ff  <= d3_idx_ff;
         rsp_frac_ff <= d3_frac;
         rsp_last_ff <= (d3_idx_ff == LAST_BIN);
      end
   end

   // remainder at or above the divisor means the estimate was one short
   assign d3_diff = {d3_cnt_ff, 16'd0} - DIFF_W'(d3_prod_ff);
   assign d3_frac = d3_sat_ff ? FRAC_ONE :
                    d3_q_ff + FRAC_W'(d3_diff >= DIFF_W'(PIXELS));

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.bin_index    = rsp_idx_ff;
   assign rsp_ch.bin_fraction = rsp_frac_ff;
   assign rsp_ch.last_bin     = rsp_last_ff;

   // ------------------------------------------------------------ checks
   `ASSERT_SAME(a_no_count_in_burst, clock, reset, s1_go, phase_ff == PH_COUNT,
      "pixel entered the counter while a burst was running")
   `ASSERT_NEXT(a_end_opens_burst, clock, reset, s2_valid_ff && s2_end_ff,
      phase_ff == PH_DRAIN && idx_ff == '0, "cell end did not start a burst")
   `ASSERT_SAME(a_no_write_on_clear, clock, reset, clear_all, !s2_valid_ff,
      "counter written during the clearing read")
   `ASSERT_SAME(a_fwd_has_writer, clock, reset, fwd_ff, s2_valid_ff,
      "forwarded count without a pending write")
   `ASSERT_SAME(a_last_is_final_bin, clock, reset, rsp_valid_ff && rsp_last_ff,
      rsp_idx_ff == LAST_BIN, "last_bin flagged on a bin other than the final one")

endmodule

FILE: tb/tb_uniform_lbp_cell_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uniform_lbp_cell_histogram
// streams 3x3 pixel windows into the histogram block and checks every emitted
// bin fraction against a local uniform lbp predictor; both channels idle at
// random, and one long receiver hold-off backs the block up into its input
// ----------------------------------------------------------------------------
module tb_uniform_lbp_cell_histogram;
   import ulbp_pkg::*;

   localparam int unsigned CELL_SIZE      = 40;
   localparam int unsigned RANDOM_WINDOWS = 250;
   localparam int unsigned LONG_CELL      = 100;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned QUIET_LIMIT    = 5000;

   typedef enum int unsigned {
      PACE_FULL,
      PACE_LIGHT,
      PACE_HEAVY
   } pace_type;

   // neighbors kept in code weight order: up_left first, up last
   typedef struct {
      logic [PIX_W-1:0] centre;
      logic [PIX_W-1:0] nb [8];
      logic             inside_image;
      logic             cell_end;
   } window_type;

   typedef struct {
      logic [BIN_W-1:0]  bin_index;
      logic [FRAC_W-1:0] bin_fraction;
      logic              last_bin;
   } bin_result_type;

   logic clock;
   logic reset = 1'b1;

   ulbp_req_if req_ch ();
   ulbp_rsp_if rsp_ch ();

   uniform_lbp_cell_histogram #(
      .CELL_SIZE (CELL_SIZE)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   window_type     pixel_q [$];
   bin_result_type bins_expected [$];
   logic [BIN_W-1:0] code_bin [256];
   logic [CNT_W-1:0] bin_count [NUM_BINS];

   window_type     next_win;
   window_type     seen_win;
   bin_result_type bin_want;
   logic [CODE_W-1:0] seen_code;
   longint unsigned frac_wide;

   logic        req_taken;
   int unsigned req_gap;
   int unsigned rsp_stall;
   pace_type    req_pace = PACE_FULL;
   pace_type    rsp_pace = PACE_FULL;
   bit          pressure_done;
   int unsigned quiet_cycles;
   int unsigned windows_total;
   int unsigned windows_taken;
   int unsigned cells_closed;
   int unsigned bins_checked;
   int unsigned error_count;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int unsigned ring_flips(logic [CODE_W-1:0] code);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 8; i++) begin
         if (code[i] != code[(i + 1) % 8]) n++;
      end
      return n;
   endfunction

   // neighbors above the centre where the code has a one, at or below elsewhere
   function automatic window_type make_window(logic [CODE_W-1:0] code, logic in_image,
                                              logic cell_end);
      window_type w;
      w.centre = (code == '0) ? PIX_W'($urandom_range(0, 255))
                              : PIX_W'($urandom_range(0, 254));
      for (int i = 0; i < 8; i++) begin
         if (code[i]) w.nb[i] = PIX_W'($urandom_range(int'(w.centre) + 1, 255));
         else         w.nb[i] = PIX_W'($urandom_range(0, int'(w.centre)));
      end
      w.inside_image = in_image;
      w.cell_end     = cell_end;
      return w;
   endfunction

   function automatic window_type flat_window(logic [PIX_W-1:0] centre,
                                              logic [PIX_W-1:0] level,
                                              logic in_image, logic cell_end);
      window_type w;
      w.centre = centre;
      for (int i = 0; i < 8; i++) w.nb[i] = level;
      w.inside_image = in_image;
      w.cell_end     = cell_end;
      return w;
   endfunction

   // append one window to the pending stimulus
   function automatic void queue_window(window_type w);
      pixel_q = {pixel_q, w};
   endfunction

   function automatic int unsigned idle_len(pace_type pace);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (pace == PACE_FULL) return 0;
      if (pace == PACE_LIGHT) begin
         if (r < 70) return 0;
         if (r < 97) return $urandom_range(1, 3);
         return $urandom_range(10, 40);
      end
      if (r < 35) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(8, 40);
   endfunction

   // pixel window driver
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pixel_q.size() != 0) begin
            next_win = pixel_q.pop_front();
            req_ch.center_pixel <= next_win.centre;
            req_ch.up_left      <= next_win.nb[0];
            req_ch.left         <= next_win.nb[1];
            req_ch.down_left    <= next_win.nb[2];
            req_ch.down         <= next_win.nb[3];
            req_ch.down_right   <= next_win.nb[4];
            req_ch.right        <= next_win.nb[5];
            req_ch.up_right     <= next_win.nb[6];
            req_ch.up           <= next_win.nb[7];
            req_ch.inside_image <= next_win.inside_image;
            req_ch.cell_end     <= next_win.cell_end;
            req_ch.valid        <= 1'b1;
            if ($urandom_range(0, 63) == 0) req_pace = pace_type'($urandom_range(0, 2));
            req_gap = idle_len(req_pace);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // bin receiver: random stalls plus one long hold-off while windows are pending
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!pressure_done && bins_expected.size() != 0 && pixel_q.size() > 50) begin
            pressure_done = 1'b1;
            rsp_stall     = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 99) == 0) rsp_pace = pace_type'($urandom_range(0, 2));
            rsp_stall = idle_len(rsp_pace);
            if (rsp_stall == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_stall--;
               rsp_ch.ready <= 1'b0;
            end
         end
      end
   end

   // monitor: histogram prediction, bin checks and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles = 0;
         for (int i = 0; i < NUM_BINS; i++) bin_count[i] = '0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;

         if (req_ch.valid && req_ch.ready) begin
            seen_win.centre = req_ch.center_pixel;
            seen_win.nb     = '{req_ch.up_left, req_ch.left, req_ch.down_left, req_ch.down,
                                req_ch.down_right, req_ch.right, req_ch.up_right, req_ch.up};
            seen_code = '0;
            if (req_ch.inside_image) begin
               for (int i = 0; i < 8; i++) seen_code[i] = seen_win.nb[i] > seen_win.centre;
            end
            if (bin_count[code_bin[seen_code]] != CNT_MAX)
               bin_count[code_bin[seen_code]]++;
            windows_taken++;
            if (req_ch.cell_end) begin
               for (int i = 0; i < NUM_BINS; i++) begin
                  frac_wide = longint'(bin_count[i]) * 65536 / (CELL_SIZE * CELL_SIZE);
                  if (frac_wide > FRAC_ONE) frac_wide = FRAC_ONE;
                  bin_want.bin_index    = BIN_W'(i);
                  bin_want.bin_fraction = FRAC_W'(frac_wide);
                  bin_want.last_bin     = (BIN_W'(i) == LAST_BIN);
                  bins_expected = {bins_expected, bin_want};
                  bin_count[i] = '0;
               end
               cells_closed++;
            end
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (bins_expected.size() == 0) begin
               $error("bin transaction with nothing expected: bin_index %0d bin_fraction %0d",
                      rsp_ch.bin_index, rsp_ch.bin_fraction);
               error_count++;
            end else begin
               bin_want = bins_expected.pop_front();
               if (rsp_ch.bin_index !== bin_want.bin_index) begin
                  $error("bin_index: expected %0d, got %0d", bin_want.bin_index,
                         rsp_ch.bin_index);
                  error_count++;
               end
               if (rsp_ch.bin_fraction !== bin_want.bin_fraction) begin
                  $error("bin_fraction (bin %0d): expected %0d, got %0d", bin_want.bin_index,
                         bin_want.bin_fraction, rsp_ch.bin_fraction);
                  error_count++;
               end
               if (rsp_ch.last_bin !== bin_want.last_bin) begin
                  $error("last_bin (bin %0d): expected %0d, got %0d", bin_want.bin_index,
                         bin_want.last_bin, rsp_ch.last_bin);
                  error_count++;
               end
               bins_checked++;
            end
         end

         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT) begin
               $display("tb_uniform_lbp_cell_histogram NOT OK");
               $finish;
            end
         end
      end
   end

   initial begin
      int unsigned next_bin;
      int unsigned sel;
      logic [CODE_W-1:0] code;
      logic cell_end;

      req_ch.valid        = 1'b0;
      req_ch.center_pixel = '0;
      req_ch.up_left      = '0;
      req_ch.left         = '0;
      req_ch.down_left    = '0;
      req_ch.down         = '0;
      req_ch.down_right   = '0;
      req_ch.right        = '0;
      req_ch.up_right     = '0;
      req_ch.up           = '0;
      req_ch.inside_image = 1'b0;
      req_ch.cell_end     = 1'b0;
      rsp_ch.ready        = 1'b0;

      next_bin = 1;
      for (int c = 0; c < 256; c++) begin
         if (ring_flips(CODE_W'(c)) <= 2) begin
            code_bin[c] = BIN_W'(next_bin);
            next_bin++;
         end else begin
            code_bin[c] = '0;
         end
      end

      // directed: extremes, strict compare, border, each single bit, wrap-around
      queue_window(flat_window(8'd0, 8'd255, 1'b1, 1'b0));
      queue_window(flat_window(8'd255, 8'd0, 1'b1, 1'b0));
      queue_window(flat_window(8'd255, 8'd255, 1'b1, 1'b0));
      queue_window(flat_window(8'd0, 8'd255, 1'b0, 1'b0));
      queue_window(flat_window(8'd0, 8'd0, 1'b1, 1'b0));
      for (int i = 0; i < 8; i++) queue_window(make_window(CODE_W'(1 << i), 1'b1, 1'b0));
      queue_window(make_window(8'h55, 1'b1, 1'b0));
      queue_window(make_window(8'hAA, 1'b1, 1'b0));
      queue_window(make_window(8'h81, 1'b1, 1'b0));
      queue_window(make_window(8'h7E, 1'b1, 1'b1));
      // two cells holding only their closing pixel, then a cell of two
      queue_window(flat_window(8'd128, 8'd128, 1'b1, 1'b1));
      queue_window(make_window(8'h5A, 1'b1, 1'b1));
      queue_window(make_window(8'hF0, 1'b1, 1'b0));
      queue_window(make_window(8'h0F, 1'b0, 1'b1));

      // long cell: the all-zero code bin dominates its histogram
      for (int i = 0; i < LONG_CELL; i++) begin
         if (i % 50 == 0) code = 8'h01;
         else             code = '0;
         queue_window(make_window(code, (i % 50 == 0) ? 1'b1 : 1'($urandom_range(0, 1)),
                                  (i == LONG_CELL - 1)));
      end

      // random: mostly uniform codes, plus noise, border and flat windows
      for (int n = 0; n < RANDOM_WINDOWS; n++) begin
         sel      = $urandom_range(0, 99);
         cell_end = ($urandom_range(0, 9) == 0) || (n == RANDOM_WINDOWS - 1);
         if (sel < 60) begin
            do code = CODE_W'($urandom_range(0, 255)); while (code_bin[code] == '0);
            queue_window(make_window(code, 1'b1, cell_end));
         end else if (sel < 80) begin
            next_win.centre = PIX_W'($urandom_range(0, 255));
            for (int i = 0; i < 8; i++) next_win.nb[i] = PIX_W'($urandom_range(0, 255));
            next_win.inside_image = 1'($urandom_range(0, 1));
            next_win.cell_end     = cell_end;
            queue_window(next_win);
         end else if (sel < 90) begin
            queue_window(make_window(CODE_W'($urandom_range(0, 255)), 1'b0, cell_end));
         end else begin
            code = CODE_W'($urandom_range(0, 255));
            queue_window(flat_window(code, code, 1'b1, cell_end));
         end
      end
      windows_total = pixel_q.size();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      while (windows_taken != windows_total || bins_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d pixel windows in %0d cells, %0d bin transactions compared",
               windows_taken, cells_closed, bins_checked);
      $display("included a %0d-pixel cell dominated by a single bin", LONG_CELL);
      if (error_count == 0 && bins_expected.size() == 0) begin
         $display("tb_uniform_lbp_cell_histogram OK");
      end else begin
         $display("tb_uniform_lbp_cell_histogram NOT OK");
      end
      $finish;
   end

endmodule
